### rtl/ppc_pkg.sv
package ppc_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 120;
  localparam int unsigned SCREEN_HEIGHT_DEF = 192;
  localparam int unsigned SCREEN_TOP_DEF    = 8;

  localparam int unsigned APB_AW = 6;
  localparam int unsigned APB_DW = 64;

  localparam logic [47:0] ROW_X_RST  = 48'd256;
  localparam logic [47:0] ROW_Y_RST  = 48'd16777216;
  localparam logic [47:0] ROW_Z_RST  = 48'd1099511627776;
  localparam logic [47:0] OFFSET_RST = 48'd43980465111040;
  localparam logic [14:0] CANVAS_RST = 15'd512;

  typedef enum logic [2:0] {
    REG_ROW_X    = 3'd0,
    REG_ROW_Y    = 3'd1,
    REG_ROW_Z    = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_CANVAS_W = 3'd4,
    REG_CANVAS_H = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [47:0] row_x;
    logic [47:0] row_y;
    logic [47:0] row_z;
    logic [47:0] offset;
    logic [14:0] canvas_w;
    logic [14:0] canvas_h;
  } cfg_t;

endpackage

### rtl/ppc_if.sv
interface ppc_pt_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] point_x;
  logic signed [15:0] point_y;
  logic signed [15:0] point_z;

  modport source (output valid, point_x, point_y, point_z, input ready);
  modport sink   (input valid, point_x, point_y, point_z, output ready);
endinterface

interface ppc_scr_if;
  logic       valid;
  logic       ready;
  logic [7:0] screen_x;
  logic [7:0] screen_y;
  logic       on_screen;

  modport source (output valid, screen_x, screen_y, on_screen, input ready);
  modport sink   (input valid, screen_x, screen_y, on_screen, output ready);
endinterface

### rtl/ppc_regs.sv
module ppc_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ppc_pkg::APB_AW-1:0]  paddr,
  input  logic [ppc_pkg::APB_DW-1:0]  pwdata,
  output logic [ppc_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  output ppc_pkg::cfg_t               cfg_o
);

  ppc_pkg::cfg_t    cfg_q;
  ppc_pkg::reg_idx_e idx;
  logic             wr;

  assign idx    = ppc_pkg::reg_idx_e'(paddr[5:3]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row_x    <= ppc_pkg::ROW_X_RST;
      cfg_q.row_y    <= ppc_pkg::ROW_Y_RST;
      cfg_q.row_z    <= ppc_pkg::ROW_Z_RST;
      cfg_q.offset   <= ppc_pkg::OFFSET_RST;
      cfg_q.canvas_w <= ppc_pkg::CANVAS_RST;
      cfg_q.canvas_h <= ppc_pkg::CANVAS_RST;
    end else if (wr) begin
      unique case (idx)
        ppc_pkg::REG_ROW_X:    cfg_q.row_x    <= pwdata[47:0];
        ppc_pkg::REG_ROW_Y:    cfg_q.row_y    <= pwdata[47:0];
        ppc_pkg::REG_ROW_Z:    cfg_q.row_z    <= pwdata[47:0];
        ppc_pkg::REG_OFFSET:   cfg_q.offset   <= pwdata[47:0];
        ppc_pkg::REG_CANVAS_W: cfg_q.canvas_w <= pwdata[14:0];
        ppc_pkg::REG_CANVAS_H: cfg_q.canvas_h <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      ppc_pkg::REG_ROW_X:    prdata = {16'd0, cfg_q.row_x};
      ppc_pkg::REG_ROW_Y:    prdata = {16'd0, cfg_q.row_y};
      ppc_pkg::REG_ROW_Z:    prdata = {16'd0, cfg_q.row_z};
      ppc_pkg::REG_OFFSET:   prdata = {16'd0, cfg_q.offset};
      ppc_pkg::REG_CANVAS_W: prdata = {49'd0, cfg_q.canvas_w};
      ppc_pkg::REG_CANVAS_H: prdata = {49'd0, cfg_q.canvas_h};
      default:               prdata = '0;
    endcase
  end

endmodule

### rtl/ppc_xform.sv
module ppc_xform (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic signed [15:0] px_i,
  input  logic signed [15:0] py_i,
  input  logic signed [15:0] pz_i,
  input  ppc_pkg::cfg_t      cfg_i,
  output logic               valid_o,
  output logic signed [15:0] cx_o,
  output logic signed [15:0] cy_o,
  output logic signed [15:0] cz_o
);

  logic               v1_q, v2_q;
  logic signed [31:0] prod_q [3][3];
  logic signed [15:0] cam_q  [3];
  logic signed [15:0] cam_d  [3];

  // stage one: nine coefficient products
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) begin
        prod_q[k][0] <= px_i * signed'(cfg_i.row_x[16*k +: 16]);
        prod_q[k][1] <= py_i * signed'(cfg_i.row_y[16*k +: 16]);
        prod_q[k][2] <= pz_i * signed'(cfg_i.row_z[16*k +: 16]);
      end
    end
  end

  // stage two: add translation, divide by 256 toward zero, keep 16 bits
  always_comb begin
    logic signed [33:0] s;
    logic signed [33:0] adj;
    for (int k = 0; k < 3; k++) begin
      s = 34'(prod_q[k][0]) + 34'(prod_q[k][1]) + 34'(prod_q[k][2])
        + {{10{cfg_i.offset[16*k+15]}}, cfg_i.offset[16*k +: 16], 8'd0};
      adj = s + (s[33] ? 34'sd255 : 34'sd0);
      cam_d[k] = adj[23:8];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < 3; k++) cam_q[k] <= cam_d[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
    end
  end

  assign valid_o = v2_q;
  assign cx_o    = cam_q[0];
  assign cy_o    = cam_q[1];
  assign cz_o    = cam_q[2];

endmodule

### rtl/ppc_div.sv
module ppc_div #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16,
  parameter int unsigned SW = 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [NW-1:0] num_i,
  input  logic signed [DW-1:0] den_i,
  input  logic [SW-1:0]        side_i,
  output logic                 valid_o,
  output logic signed [NW-1:0] quo_o,
  output logic [SW-1:0]        side_o
);

  logic          v_q   [NW+1];
  logic [NW-1:0] n_q   [NW+1];
  logic [DW-1:0] rem_q [NW+1];
  logic [DW-1:0] d_q   [NW+1];
  logic          neg_q [NW+1];
  logic [SW-1:0] s_q   [NW+1];

  logic [NW-1:0] num_mag;
  logic [DW-1:0] den_mag;

  assign num_mag = num_i[NW-1] ? (~num_i + 1'b1) : num_i;
  assign den_mag = den_i[DW-1] ? (~den_i + 1'b1) : den_i;

  // entry stage: take magnitudes, remember the quotient sign
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q[0]   <= num_mag;
      d_q[0]   <= den_mag;
      rem_q[0] <= '0;
      neg_q[0] <= num_i[NW-1] ^ den_i[DW-1];
      s_q[0]   <= side_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= valid_i;
  end

  // one restoring step per stage, quotient bits shift in behind the dividend
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;

    assign t    = {rem_q[k], n_q[k][NW-1]};
    assign diff = t - {1'b0, d_q[k]};
    assign ge   = t >= {1'b0, d_q[k]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k+1]   <= {n_q[k][NW-2:0], ge};
        rem_q[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        d_q[k+1]   <= d_q[k];
        neg_q[k+1] <= neg_q[k];
        s_q[k+1]   <= s_q[k];
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k+1] <= 1'b0;
      else if (en_i) v_q[k+1] <= v_q[k];
    end
  end

  assign valid_o = v_q[NW];
  assign quo_o   = neg_q[NW] ? signed'(~n_q[NW] + 1'b1) : signed'(n_q[NW]);
  assign side_o  = s_q[NW];

endmodule

### rtl/perspective_project_and_clip_unit.sv
// Perspective projection of signed 8.8 vertices to screen pixels.
//
// Vertices arrive on pt_i (valid/ready); each transaction yields exactly one
// result on scr_o: pixel column, pixel row plus top offset, and an on-screen
// flag. Off-screen, zero-depth or zero-canvas points give column 255, row 0.
// The camera matrix and canvas size sit in an APB register file (64-bit
// data, register i at byte address 8*i); write them only while idle.
//
// Throughput: one vertex per cycle while scr_o is not stalled. A result
// passes two stages of matrix multiply and sum, 25 stages of the depth
// divider (an entry stage, then one quotient bit per stage), one canvas
// scaling stage, 26 stages of the canvas divider and the output register.
//
// The whole pipeline advances while the output register is empty or being
// taken. When the receiver stalls with a result waiting, every stage holds
// and pt_i.ready drops; nothing is lost or repeated.
//
// Reset clears all valid bits and loads the default registers: identity
// matrix, depth offset of 40, canvas 2.0 by 2.0.
module perspective_project_and_clip_unit #(
  parameter int unsigned SCREEN_WIDTH  = ppc_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = ppc_pkg::SCREEN_HEIGHT_DEF,
  parameter int unsigned SCREEN_TOP    = ppc_pkg::SCREEN_TOP_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  ppc_pt_if.sink                     pt_i,
  ppc_scr_if.source                  scr_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppc_pkg::APB_AW-1:0] paddr,
  input  logic [ppc_pkg::APB_DW-1:0] pwdata,
  output logic [ppc_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  ppc_pkg::cfg_t cfg;
  logic          en;

  logic               xf_valid;
  logic signed [15:0] cx, cy, cz;

  logic               d1_valid;
  logic signed [23:0] qx, qy;
  logic               d1_zero;

  logic               m_valid_q;
  logic signed [24:0] nx_q, ny_q;
  logic               m_zero_q;

  logic               d2_valid;
  logic signed [24:0] q2x, q2y;
  logic               d2_zero;

  logic       out_valid_q;
  logic [7:0] sx_q, sy_q;
  logic       vis_q;

  // hold every stage while a result waits untaken
  assign en         = !out_valid_q || scr_o.ready;
  assign pt_i.ready = en;

  ppc_regs u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  ppc_xform u_xform (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(pt_i.valid),
    .px_i   (pt_i.point_x),
    .py_i   (pt_i.point_y),
    .pz_i   (pt_i.point_z),
    .cfg_i  (cfg),
    .valid_o(xf_valid),
    .cx_o   (cx),
    .cy_o   (cy),
    .cz_o   (cz)
  );

  // divide 256*cx and 256*cy by depth; the zero-depth flag rides along
  ppc_div #(.NW(24), .DW(16), .SW(1)) u_div_qx (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(xf_valid),
    .num_i  ({cx, 8'd0}),
    .den_i  (cz),
    .side_i (cz == 16'sd0),
    .valid_o(d1_valid),
    .quo_o  (qx),
    .side_o (d1_zero)
  );

  ppc_div #(.NW(24), .DW(16), .SW(1)) u_div_qy (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(xf_valid),
    .num_i  ({cy, 8'd0}),
    .den_i  (cz),
    .side_i (1'b0),
    .valid_o(),
    .quo_o  (qy),
    .side_o ()
  );

  // centre on the canvas and scale by the screen size
  logic signed [15:0] tx, ty;
  logic signed [8:0]  sw_s, sh_s;

  assign sw_s = signed'({1'b0, SCREEN_WIDTH[7:0]});
  assign sh_s = signed'({1'b0, SCREEN_HEIGHT[7:0]});
  assign tx   = signed'({2'd0, cfg.canvas_w[14:1]} - qx[15:0]);
  assign ty   = signed'({2'd0, cfg.canvas_h[14:1]} - qy[15:0]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q     <= 25'(tx * sw_s);
      ny_q     <= 25'(ty * sh_s);
      m_zero_q <= d1_zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else if (en) m_valid_q <= d1_valid;
  end

  ppc_div #(.NW(25), .DW(16), .SW(1)) u_div_x (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(m_valid_q),
    .num_i  (nx_q),
    .den_i  (signed'({1'b0, cfg.canvas_w})),
    .side_i (m_zero_q),
    .valid_o(d2_valid),
    .quo_o  (q2x),
    .side_o (d2_zero)
  );

  ppc_div #(.NW(25), .DW(16), .SW(1)) u_div_y (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(m_valid_q),
    .num_i  (ny_q),
    .den_i  (signed'({1'b0, cfg.canvas_h})),
    .side_i (1'b0),
    .valid_o(),
    .quo_o  (q2y),
    .side_o ()
  );

  // clip against the screen and form the result
  logic signed [15:0] x_pix, y_pix;
  logic               vis;
  logic [15:0]        y_off;

  assign x_pix = q2x[15:0];
  assign y_pix = signed'(16'(SCREEN_HEIGHT) - q2y[15:0]);
  assign y_off = y_pix + 16'(SCREEN_TOP);
  assign vis   = !d2_zero && (cfg.canvas_w != '0) && (cfg.canvas_h != '0)
              && !x_pix[15] && (x_pix < signed'(16'(SCREEN_WIDTH)))
              && !y_pix[15] && (y_pix < signed'(16'(SCREEN_HEIGHT)));

  always_ff @(posedge clk_i) begin
    if (en) begin
      sx_q  <= vis ? x_pix[7:0] : 8'hFF;
      sy_q  <= vis ? y_off[7:0] : 8'h00;
      vis_q <= vis;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= d2_valid;
  end

  assign scr_o.valid     = out_valid_q;
  assign scr_o.screen_x  = sx_q;
  assign scr_o.screen_y  = sy_q;
  assign scr_o.on_screen = vis_q;

endmodule

### rtl/ppc_chk.sv
module ppc_chk #(
  parameter int unsigned SCREEN_WIDTH = ppc_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_TOP   = ppc_pkg::SCREEN_TOP_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [7:0] screen_x_i,
  input logic [7:0] screen_y_i,
  input logic       on_screen_i
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(screen_x_i)
      && $stable(screen_y_i) && $stable(on_screen_i))
    else $error("stalled result changed");

  // input is taken exactly when the output side can move
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i == (!out_valid_i || out_ready_i))
    else $error("input ready out of step with output");

  a_clip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !on_screen_i |-> screen_x_i == 8'hFF && screen_y_i == 8'h00)
    else $error("clipped point carries coordinates");

  a_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && on_screen_i |-> screen_x_i < 8'(SCREEN_WIDTH)
      && screen_y_i >= 8'(SCREEN_TOP))
    else $error("visible point outside screen");

endmodule

bind perspective_project_and_clip_unit ppc_chk #(
  .SCREEN_WIDTH(SCREEN_WIDTH),
  .SCREEN_TOP  (SCREEN_TOP)
) u_ppc_chk (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_ready_i (pt_i.ready),
  .out_valid_i(scr_o.valid),
  .out_ready_i(scr_o.ready),
  .screen_x_i (scr_o.screen_x),
  .screen_y_i (scr_o.screen_y),
  .on_screen_i(scr_o.on_screen)
);
